@@ rtl/core/pscc_pkg.sv @@
// Shared types, codes and constants of the PV surplus charge controller.
package pscc_pkg;

  localparam int CmdW     = 3;
  localparam int ValueW   = 24;
  localparam int TimeW    = 32;
  localparam int SurplusW = 25;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 56;
  localparam int OutDataW = 40;

  localparam int FullPowerMinW    = 5500;
  localparam int StopLimitW       = -250;
  localparam int SecPerHour       = 3600;
  localparam int ActionGapS       = 10;
  localparam int SocLowDefault    = 85;
  localparam int SocHighDefault   = 95;
  localparam int SocMaxPct        = 100;
  localparam int SocClampMax      = 127;
  localparam int SocReset         = 80;
  localparam int RuntimeDefaultH  = 8;
  localparam int RuntimeMaxH      = 10;
  localparam int DischargeDefault = 4500;
  localparam int SurplusMax       = 16777215;
  localparam int SurplusMin       = -16777216;

  typedef enum logic [2:0] {
    CMD_SOLAR, CMD_HOME, CMD_SOC, CMD_CAR, CMD_MODE, CMD_PLUG, CMD_ODO, CMD_TICK
  } cmd_t;

  typedef enum logic [1:0] {CAR_OTHER, CAR_READY, CAR_CHARGING} car_t;
  typedef enum logic [1:0] {MODE_OTHER, MODE_REDUCED, MODE_MAX} mode_t;
  typedef enum logic [1:0] {CUR_NONE, CUR_REDUCED, CUR_MAX} cur_cmd_t;
  typedef enum logic [1:0] {CHG_NONE, CHG_START, CHG_STOP} chg_cmd_t;
  typedef enum logic [2:0] {
    HALT_NONE, HALT_SOLAR, HALT_UNPLUG, HALT_MOVED, HALT_RUNTIME
  } halt_t;

  typedef enum logic [2:0] {
    CFG_REDUCED_MODE, CFG_HYST_ENABLE, CFG_SOC_LOW, CFG_SOC_HIGH,
    CFG_RESERVE, CFG_DISCHARGE_MAX, CFG_RUNTIME_HOURS
  } cfg_idx_t;

  // Effective settings; SOC limits and runtime already checked against their legal ranges.
  typedef struct packed {
    logic        reduced;
    logic        hyst;
    logic [6:0]  soc_lo;
    logic [6:0]  soc_hi;
    logic [15:0] reserve;
    logic [15:0] discharge;
    logic [15:0] runtime_s;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [ValueW-1:0] value;
    logic [TimeW-1:0]         now_s;
  } item_t;

  typedef struct packed {
    logic signed [SurplusW-1:0] surplus_w;
    cur_cmd_t                   current_cmd;
    chg_cmd_t                   charge_cmd;
    halt_t                      halt_reason;
    logic                       halted;
  } result_t;

  function automatic logic [15:0] runtime_secs(input logic [3:0] hours);
    logic [3:0] hrs;
    hrs = (hours >= 4'd1 && hours <= 4'(RuntimeMaxH)) ? hours : 4'(RuntimeDefaultH);
    return 16'(int'(hrs) * SecPerHour);
  endfunction

endpackage

@@ rtl/core/pv_surplus_charge_controller_core.sv @@
// Top level of the PV surplus charge controller.
//
// Slave channel (s_*): one event per transfer. s_tuser carries the event kind
// (solar, home, house charge, car state, current mode, plug, odometer, tick),
// s_tdata carries the signed value and the time in seconds.
// Master channel (m_*): exactly one result per event: saturated surplus power,
// current-mode command, start/stop command, halt reason and the halted flag.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no event is in flight.
// An event is captured in the input register and its result in the result register.
// Throughput: one event per cycle while m_tready holds; the whole update runs in one
// stage between the input register and the result register.
// Reset: all settings and controller state go to their defaults, both
// channels empty. When the receiver stalls, the result register holds and the
// input register still takes one more event if it is empty; after that s_tready
// drops until m_tready returns.
module pv_surplus_charge_controller_core import pscc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // value[23:0], now_s[55:24]
  input  logic [CmdW-1:0]     s_tuser,   // cmd[2:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // surplus_w[24:0], current_cmd[26:25],
                                         // charge_cmd[28:27], halt_reason[31:29],
                                         // halted[32], zero[39:33]
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    item_valid;
  logic    advance;

  pscc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pscc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pscc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (item_valid && advance),
    .item (item),
    .res  (res)
  );

  pscc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

@@ rtl/core/pscc_cfg.sv @@
// Configuration registers with range checks applied to their outputs.
module pscc_cfg import pscc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  logic        reduced_mode;
  logic        hyst_enable;
  logic [6:0]  soc_low;
  logic [6:0]  soc_high;
  logic [15:0] reserve;
  logic [15:0] discharge_max;
  logic [3:0]  runtime_hours;
  logic        soc_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduced_mode  <= 1'b0;
      hyst_enable   <= 1'b1;
      soc_low       <= 7'(SocLowDefault);
      soc_high      <= 7'(SocHighDefault);
      reserve       <= '0;
      discharge_max <= 16'(DischargeDefault);
      runtime_hours <= 4'(RuntimeDefaultH);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REDUCED_MODE:  reduced_mode  <= cfg_data[0];
        CFG_HYST_ENABLE:   hyst_enable   <= cfg_data[0];
        CFG_SOC_LOW:       soc_low       <= cfg_data[6:0];
        CFG_SOC_HIGH:      soc_high      <= cfg_data[6:0];
        CFG_RESERVE:       reserve       <= cfg_data;
        CFG_DISCHARGE_MAX: discharge_max <= cfg_data;
        CFG_RUNTIME_HOURS: runtime_hours <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign soc_bad = (soc_low > 7'(SocMaxPct)) || (soc_high > 7'(SocMaxPct)) ||
                   (soc_low >= soc_high);

  always_comb begin
    cfg.reduced   = reduced_mode;
    cfg.hyst      = hyst_enable;
    cfg.soc_lo    = soc_bad ? 7'(SocLowDefault)  : soc_low;
    cfg.soc_hi    = soc_bad ? 7'(SocHighDefault) : soc_high;
    cfg.reserve   = reserve;
    cfg.discharge = discharge_max;
    cfg.runtime_s = runtime_secs(runtime_hours);
  end

endmodule

@@ rtl/core/pscc_in_reg.sv @@
// Input register: captures one event transfer from the slave channel.
module pscc_in_reg import pscc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  input  logic [CmdW-1:0]    s_tuser,
  input  logic               advance,
  output logic               item_valid,
  output item_t              item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.cmd   <= s_tuser;
      item.value <= s_tdata[ValueW-1:0];
      item.now_s <= s_tdata[ValueW+TimeW-1:ValueW];
    end
  end

endmodule

@@ rtl/core/pscc_step.sv @@
// Controller state and the per-event update, surplus and command logic.
module pscc_step import pscc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  typedef struct packed {
    logic                     support_on;
    logic signed [ValueW-1:0] solar_w;
    logic signed [ValueW-1:0] home_w;
    logic [6:0]               house_soc;
    car_t                     car_state;
    mode_t                    current_mode;
    logic                     was_plugged;
    logic signed [ValueW-1:0] odo_ref;
    logic                     odo_valid;
    logic [TimeW-1:0]         start_time;
    logic                     start_valid;
    logic [TimeW-1:0]         last_action_time;
    logic                     halt_latch;
  } state_t;

  state_t st;
  state_t st_next;

  logic signed [ValueW-1:0]   v;
  logic [TimeW-1:0]           start_eff;
  logic [TimeW:0]             limit;
  logic signed [TimeW:0]      gap;
  logic signed [26:0]         base;
  logic signed [26:0]         sum;
  logic signed [SurplusW-1:0] surp;
  logic                       action;
  halt_t                      reason;
  cur_cmd_t                   ccmd;
  chg_cmd_t                   chg;

  assign v = item.value;

  always_comb begin
    st_next   = st;
    action    = 1'b0;
    reason    = HALT_NONE;
    ccmd      = CUR_NONE;
    chg       = CHG_NONE;
    start_eff = st.start_valid ? st.start_time : item.now_s;
    limit     = {1'b0, start_eff} + 33'(cfg.runtime_s);
    gap       = $signed({1'b0, item.now_s}) - $signed({1'b0, st.last_action_time});
    base      = '0;
    sum       = '0;
    surp      = '0;

    if (!st.halt_latch) begin
      st_next.start_valid = 1'b1;
      st_next.start_time  = start_eff;

      case (cmd_t'(item.cmd))
        CMD_SOLAR: begin
          st_next.solar_w = v;
          if (v == '0) reason = HALT_SOLAR;
          else action = 1'b1;
        end
        CMD_HOME: st_next.home_w = v;
        CMD_SOC: begin
          if (v[ValueW-1]) st_next.house_soc = '0;
          else if (v > 24'(SocClampMax)) st_next.house_soc = 7'(SocClampMax);
          else st_next.house_soc = v[6:0];
        end
        CMD_CAR: begin
          st_next.car_state = (!v[ValueW-1] && v <= 24'sd2) ? car_t'(v[1:0]) : CAR_OTHER;
          action = 1'b1;
        end
        CMD_MODE: begin
          st_next.current_mode = (!v[ValueW-1] && v <= 24'sd2) ? mode_t'(v[1:0])
                                                               : MODE_OTHER;
        end
        CMD_PLUG: begin
          if (v == 24'sd1) st_next.was_plugged = 1'b1;
          else if (v == '0 && st.was_plugged) reason = HALT_UNPLUG;
        end
        CMD_ODO: begin
          // a fresh reference never trips: the first reading only sets it
          if (!st.odo_valid) begin
            st_next.odo_ref   = v;
            st_next.odo_valid = !v[ValueW-1];
          end else if (st.odo_ref != '0 && v > st.odo_ref) begin
            reason = HALT_MOVED;
          end
        end
        CMD_TICK: ;
        default: ;
      endcase

      if ({1'b0, item.now_s} > limit && reason == HALT_NONE) reason = HALT_RUNTIME;

      if (st_next.solar_w > 0) begin
        base = 27'(st_next.solar_w) - 27'(st_next.home_w);
        if (cfg.hyst) begin
          if (!st.support_on && st_next.house_soc >= cfg.soc_hi) st_next.support_on = 1'b1;
          else if (st.support_on && st_next.house_soc < cfg.soc_lo) st_next.support_on = 1'b0;
          sum = st_next.support_on ? base + $signed({11'b0, cfg.discharge})
                                   : base - $signed({11'b0, cfg.reserve});
        end else begin
          sum = base - $signed({11'b0, cfg.reserve});
        end
      end

      if (sum > 27'(SurplusMax)) surp = 25'(SurplusMax);
      else if (sum < 27'(SurplusMin)) surp = 25'(SurplusMin);
      else surp = sum[SurplusW-1:0];

      if (action && gap > 33'(ActionGapS)) begin
        st_next.last_action_time = item.now_s;
        if (cfg.reduced) begin
          if (st_next.current_mode != MODE_REDUCED) ccmd = CUR_REDUCED;
        end else if (st_next.car_state == CAR_CHARGING && surp > 25'(FullPowerMinW)) begin
          if (st_next.current_mode != MODE_MAX) ccmd = CUR_MAX;
        end else if (st_next.car_state == CAR_CHARGING && surp < 0) begin
          if (st_next.current_mode != MODE_REDUCED) ccmd = CUR_REDUCED;
        end
        if (st_next.car_state == CAR_READY && surp > 25'(FullPowerMinW)) begin
          chg = CHG_START;
        end else if (st_next.car_state == CAR_CHARGING && surp < 25'(StopLimitW) &&
                     st_next.current_mode == MODE_REDUCED) begin
          chg = CHG_STOP;
        end
      end

      if (reason != HALT_NONE) st_next.halt_latch = 1'b1;
    end

    res.surplus_w   = surp;
    res.current_cmd = ccmd;
    res.charge_cmd  = chg;
    res.halt_reason = reason;
    res.halted      = st_next.halt_latch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.support_on       <= 1'b0;
      st.solar_w          <= '1;
      st.home_w           <= '0;
      st.house_soc        <= 7'(SocReset);
      st.car_state        <= CAR_OTHER;
      st.current_mode     <= MODE_OTHER;
      st.was_plugged      <= 1'b0;
      st.odo_ref          <= '0;
      st.odo_valid        <= 1'b0;
      st.start_time       <= '0;
      st.start_valid      <= 1'b0;
      st.last_action_time <= '0;
      st.halt_latch       <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

@@ rtl/core/pscc_out_reg.sv @@
// Result register driving the master channel.
module pscc_out_reg import pscc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  result_t             res,
  output logic                advance,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata
);

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      m_tdata <= {7'b0, res.halted, res.halt_reason, res.charge_cmd,
                  res.current_cmd, res.surplus_w};
    end
  end

endmodule
